@@ design/wsd_pkg.sv @@
package wsd_pkg;

    // Length codes in the second header byte that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Extended-length and mask-key byte counts
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    // Result tdata: 17 used bits, padded to whole bytes
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = 7;

    typedef enum logic [4:0] {
        ST_HDR0    = 5'b00001,
        ST_HDR1    = 5'b00010,
        ST_EXTLEN  = 5'b00100,
        ST_MASKKEY = 5'b01000,
        ST_PAYLOAD = 5'b10000
    } parse_state_t;

endpackage

@@ design/websocket_frame_deframer.sv @@
// A result reaches the m_ side in the cycle after its beat is accepted.
// Throughput: one stream byte per cycle unless stalled; the header parse,
// 64-bit length count and unmasking XOR are all done in one pass into the
// result register. A held result stalls the input only while m_tready is low.
// Reset: synchronous, active-low aresetn; parser returns to expecting the first
// header byte with all header, length and key state cleared.
module websocket_frame_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] payload_byte, [8] fin_flag, [11:9] rsv_bits, [15:12] frame_opcode,
    // [16] mask_flag, [23:17] zero
    output logic [wsd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,   // last_of_frame
    output logic [0:0]                     m_tuser    // [0] data_valid
);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    wsd_pkg::parse_state_t state_reg, state_next;
    logic [3:0]  ext_left_reg, ext_left_next;   // ext-length / key bytes to come
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opc_reg, opc_next;
    logic        masked_reg, masked_next;
    logic [63:0] remain_reg, remain_next;       // payload bytes still to come
    logic [31:0] key_reg, key_next;             // key octet 0 in [31:24]
    logic [1:0]  mphase_reg, mphase_next;       // next key octet index

    // Result register
    logic                          m_valid_reg;
    logic [wsd_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_last_reg;
    logic                          m_user_reg;

    logic        s_fire;
    logic        emit;        // this beat produces a result
    logic [7:0]  res_byte;
    logic        res_valid;
    logic        res_last;

    logic [6:0]  len_code;
    logic [3:0]  ext_dec;
    logic [63:0] remain_shift;
    logic [63:0] remain_dec;
    logic [7:0]  key_byte;

    // The result register frees up in the same cycle it is drained
    assign s_tready = ~m_valid_reg | m_tready;
    assign s_fire   = s_tvalid & s_tready;

    assign len_code     = s_tdata[6:0];
    assign ext_dec      = ext_left_reg - 4'd1;
    assign remain_shift = {remain_reg[55:0], s_tdata};
    assign remain_dec   = remain_reg - 64'd1;

    always_comb begin
        unique case (mphase_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // ------------------------------------------------------------------
    // Next-state and result logic, evaluated for the beat being accepted
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        ext_left_next = ext_left_reg;
        fin_next      = fin_reg;
        rsv_next      = rsv_reg;
        opc_next      = opc_reg;
        masked_next   = masked_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        mphase_next   = mphase_reg;
        emit          = 1'b0;
        res_byte      = 8'd0;
        res_valid     = 1'b0;
        res_last      = 1'b0;

        if (s_fire) begin
            unique case (state_reg)
                wsd_pkg::ST_HDR1: begin
                    masked_next = s_tdata[7];
                    if (len_code == wsd_pkg::LEN_CODE_16) begin
                        remain_next   = 64'd0;
                        ext_left_next = wsd_pkg::EXT_BYTES_16;
                        state_next    = wsd_pkg::ST_EXTLEN;
                    end else if (len_code == wsd_pkg::LEN_CODE_64) begin
                        remain_next   = 64'd0;
                        ext_left_next = wsd_pkg::EXT_BYTES_64;
                        state_next    = wsd_pkg::ST_EXTLEN;
                    end else begin
                        remain_next = {57'd0, len_code};
                        mphase_next = 2'd0;
                        if (s_tdata[7]) begin
                            ext_left_next = wsd_pkg::KEY_BYTES;
                            key_next      = 32'd0;
                            state_next    = wsd_pkg::ST_MASKKEY;
                        end else begin
                            ext_left_next = 4'd0;
                            if (len_code == 7'd0) begin
                                emit       = 1'b1;
                                res_last   = 1'b1;
                                state_next = wsd_pkg::ST_HDR0;
                            end else begin
                                state_next = wsd_pkg::ST_PAYLOAD;
                            end
                        end
                    end
                end
                wsd_pkg::ST_EXTLEN: begin
                    remain_next   = remain_shift;
                    ext_left_next = ext_dec;
                    if (ext_dec == 4'd0) begin
                        mphase_next = 2'd0;
                        if (masked_reg) begin
                            ext_left_next = wsd_pkg::KEY_BYTES;
                            key_next      = 32'd0;
                            state_next    = wsd_pkg::ST_MASKKEY;
                        end else if (remain_shift == 64'd0) begin
                            emit       = 1'b1;
                            res_last   = 1'b1;
                            state_next = wsd_pkg::ST_HDR0;
                        end else begin
                            state_next = wsd_pkg::ST_PAYLOAD;
                        end
                    end
                end
                wsd_pkg::ST_MASKKEY: begin
                    key_next      = {key_reg[23:0], s_tdata};
                    ext_left_next = ext_dec;
                    if (ext_dec == 4'd0) begin
                        if (remain_reg == 64'd0) begin
                            emit       = 1'b1;
                            res_last   = 1'b1;
                            state_next = wsd_pkg::ST_HDR0;
                        end else begin
                            state_next = wsd_pkg::ST_PAYLOAD;
                        end
                    end
                end
                wsd_pkg::ST_PAYLOAD: begin
                    emit        = 1'b1;
                    res_valid   = 1'b1;
                    res_byte    = masked_reg ? (s_tdata ^ key_byte) : s_tdata;
                    mphase_next = mphase_reg + 2'd1;
                    remain_next = remain_dec;
                    res_last    = (remain_dec == 64'd0);
                    if (remain_dec == 64'd0) begin
                        mphase_next = 2'd0;
                        state_next  = wsd_pkg::ST_HDR0;
                    end
                end
                default: begin
                    // first header byte; illegal codes recover here too
                    fin_next      = s_tdata[7];
                    rsv_next      = s_tdata[6:4];
                    opc_next      = s_tdata[3:0];
                    masked_next   = 1'b0;
                    remain_next   = 64'd0;
                    ext_left_next = 4'd0;
                    key_next      = 32'd0;
                    mphase_next   = 2'd0;
                    state_next    = wsd_pkg::ST_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wsd_pkg::ST_HDR0;
            ext_left_reg <= 4'd0;
            fin_reg      <= 1'b0;
            rsv_reg      <= 3'd0;
            opc_reg      <= 4'd0;
            masked_reg   <= 1'b0;
            remain_reg   <= 64'd0;
            key_reg      <= 32'd0;
            mphase_reg   <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ext_left_reg <= ext_left_next;
            fin_reg      <= fin_next;
            rsv_reg      <= rsv_next;
            opc_reg      <= opc_next;
            masked_reg   <= masked_next;
            remain_reg   <= remain_next;
            key_reg      <= key_next;
            mphase_reg   <= mphase_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: header fields are taken after this beat's update
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= {{wsd_pkg::M_PAD_W{1'b0}}, masked_next, opc_next,
                           rsv_next, fin_next, res_byte};
            m_last_reg <= res_last;
            m_user_reg <= res_valid;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef SYNTHESIS
    // Header-only result is always the frame's last and carries a zero byte
    a_hdr_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_user_reg) |-> (m_last_reg && m_data_reg[7:0] == 8'd0))
        else $error("header-only result malformed");

    // A payload byte always yields a result on the next cycle
    a_payload_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg == wsd_pkg::ST_PAYLOAD) |=> m_valid_reg)
        else $error("payload byte produced no result");

    // Payload state is never entered or kept with nothing left to send
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsd_pkg::ST_PAYLOAD) |-> (remain_reg != 64'd0))
        else $error("payload state with zero remaining");

    // Byte counter only live while collecting length or key bytes
    a_ext_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsd_pkg::ST_HDR0 || state_reg == wsd_pkg::ST_HDR1 ||
         state_reg == wsd_pkg::ST_PAYLOAD) |-> (ext_left_reg == 4'd0))
        else $error("stray header byte count");
`endif

endmodule

@@ test/ws_deframe_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the parser state and compares
// each result beat with the oldest expected one.
module ws_deframe_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] payload_byte, [8] fin_flag, [11:9] rsv_bits, [15:12] frame_opcode,
    // [16] mask_flag, [23:17] zero
    input  logic [wsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,   // last_of_frame
    input  logic [0:0]                    m_tuser,   // [0] data_valid
    output int                            n_fail,
    output int                            n_pending,
    output int                            n_payload,
    output int                            n_empty
);

    typedef struct packed {
        logic [7:0] pay;
        logic       valid;
        logic       last;
        logic       fin;
        logic [2:0] rsv;
        logic [3:0] opc;
        logic       masked;
    } ws_beat_t;

    // parser copy
    wsd_pkg::parse_state_t phase;
    logic [3:0]   bytes_left;
    logic         fin_q;
    logic [2:0]   rsv_q;
    logic [3:0]   opc_q;
    logic         masked_q;
    logic [63:0]  remaining;
    logic [31:0]  key;
    logic [1:0]   key_idx;

    ws_beat_t unmasked_beats[$];

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        n_fail++;
        if (n_fail <= 30)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    task automatic post_result(input logic [7:0] pay, input logic valid, input logic last);
        unmasked_beats.push_back('{pay, valid, last, fin_q, rsv_q, opc_q, masked_q});
    endtask

    // header complete: empty frame closes at once
    task automatic close_header();
        bytes_left = '0;
        if (remaining == 64'd0) begin
            phase = wsd_pkg::ST_HDR0;
            post_result(8'h00, 1'b0, 1'b1);
        end else begin
            phase = wsd_pkg::ST_PAYLOAD;
        end
    endtask

    task automatic close_length();
        key_idx = '0;
        if (masked_q) begin
            bytes_left = wsd_pkg::KEY_BYTES;
            key        = '0;
            phase      = wsd_pkg::ST_MASKKEY;
        end else begin
            close_header();
        end
    endtask

    task automatic parse_stream_byte(input logic [7:0] b);
        logic [7:0] k;
        logic       last;
        case (phase)
            wsd_pkg::ST_HDR1: begin
                masked_q  = b[7];
                remaining = '0;
                if (b[6:0] == wsd_pkg::LEN_CODE_16) begin
                    bytes_left = wsd_pkg::EXT_BYTES_16;
                    phase      = wsd_pkg::ST_EXTLEN;
                end else if (b[6:0] == wsd_pkg::LEN_CODE_64) begin
                    bytes_left = wsd_pkg::EXT_BYTES_64;
                    phase      = wsd_pkg::ST_EXTLEN;
                end else begin
                    remaining = 64'(b[6:0]);
                    close_length();
                end
            end
            wsd_pkg::ST_EXTLEN: begin
                remaining  = {remaining[55:0], b};
                bytes_left = bytes_left - 4'd1;
                if (bytes_left == 4'd0)
                    close_length();
            end
            wsd_pkg::ST_MASKKEY: begin
                key        = {key[23:0], b};
                bytes_left = bytes_left - 4'd1;
                if (bytes_left == 4'd0)
                    close_header();
            end
            wsd_pkg::ST_PAYLOAD: begin
                k         = masked_q ? key[8*(3-key_idx) +: 8] : 8'h00;
                key_idx   = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                last      = (remaining == 64'd0);
                if (last) begin
                    phase   = wsd_pkg::ST_HDR0;
                    key_idx = '0;
                end
                post_result(b ^ k, 1'b1, last);
            end
            default: begin
                // first header byte; any stray phase lands here too
                fin_q      = b[7];
                rsv_q      = b[6:4];
                opc_q      = b[3:0];
                masked_q   = 1'b0;
                remaining  = '0;
                bytes_left = '0;
                key        = '0;
                key_idx    = '0;
                phase      = wsd_pkg::ST_HDR1;
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        ws_beat_t want;
        ws_beat_t got;
        if (!aresetn) begin
            phase      = wsd_pkg::ST_HDR0;
            bytes_left = '0;
            fin_q      = 1'b0;
            rsv_q      = '0;
            opc_q      = '0;
            masked_q   = 1'b0;
            remaining  = '0;
            key        = '0;
            key_idx    = '0;
            unmasked_beats.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[8], m_tdata[11:9],
                        m_tdata[15:12], m_tdata[16]};
                if (unmasked_beats.size() == 0) begin
                    report_mismatch("result beat with none expected", 64'd0, 64'(got));
                end else begin
                    want = unmasked_beats.pop_front();
                    check_field("payload_byte", want.pay, got.pay);
                    check_field("data_valid", want.valid, got.valid);
                    check_field("last_of_frame", want.last, got.last);
                    check_field("fin_flag", want.fin, got.fin);
                    check_field("rsv_bits", want.rsv, got.rsv);
                    check_field("frame_opcode", want.opc, got.opc);
                    check_field("mask_flag", want.masked, got.masked);
                    check_field("tdata padding", '0,
                                m_tdata[wsd_pkg::M_TDATA_W-1 -: wsd_pkg::M_PAD_W]);
                    if (want.valid)
                        n_payload++;
                    else
                        n_empty++;
                end
            end
            if (s_tvalid && s_tready)
                parse_stream_byte(s_tdata);
        end
        n_pending = unmasked_beats.size();
    end

endmodule

@@ test/websocket_frame_deframer_tb.sv @@
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 11;
    localparam int ITEM_TARGET = 1700;  // random stream bytes to build
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int HOLD_AFTER  = 600;   // start hold once this many bytes went in
    localparam int IDLE_LIMIT  = 5000;  // cycles without any beat before giving up

    // RFC 6455 opcodes used for well-formed frames
    localparam logic [3:0] OP_CONTINUATION = 4'h0;
    localparam logic [3:0] OP_TEXT         = 4'h1;
    localparam logic [3:0] OP_BINARY       = 4'h2;
    localparam logic [3:0] OP_CLOSE        = 4'h8;
    localparam logic [3:0] OP_PING         = 4'h9;
    localparam logic [3:0] OP_PONG         = 4'hA;

    // how the payload length is carried in the header
    typedef enum int {
        LEN_INLINE,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;  // [7:0] data_byte
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [7:0] payload_byte, [8] fin_flag, [11:9] rsv_bits, [15:12] frame_opcode,
    // [16] mask_flag, [23:17] zero
    logic [wsd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;           // last_of_frame
    logic [0:0]                    m_tuser;           // [0] data_valid

    int n_fail;
    int n_pending;
    int n_payload;
    int n_empty;

    logic [7:0] stream_q[$];  // the whole byte stream, built up front
    int         n_frames = 0;
    int         n_sent   = 0;
    int         idle_cycles = 0;

    websocket_frame_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    ws_deframe_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .n_fail    (n_fail),
        .n_pending (n_pending),
        .n_payload (n_payload),
        .n_empty   (n_empty)
    );

    always #CLK_HALF aclk = ~aclk;

    // Append one frame: header byte, length code (+ extended length), optional
    // key, then n_body random payload bytes. n_body may fall short of len to
    // leave a frame open at the end of the stream.
    task automatic build_frame(input logic [7:0] hdr0, input logic [63:0] len,
                               input len_form_t form, input logic masked,
                               input logic [31:0] mkey, input int unsigned n_body);
        int i;
        stream_q.push_back(hdr0);
        case (form)
            LEN_INLINE: begin
                stream_q.push_back({masked, len[6:0]});
            end
            LEN_EXT16: begin
                stream_q.push_back({masked, wsd_pkg::LEN_CODE_16});
                stream_q.push_back(len[15:8]);
                stream_q.push_back(len[7:0]);
            end
            default: begin
                stream_q.push_back({masked, wsd_pkg::LEN_CODE_64});
                for (i = 7; i >= 0; i--)
                    stream_q.push_back(len[8*i +: 8]);   // big-endian
            end
        endcase
        if (masked) begin
            for (i = 3; i >= 0; i--)
                stream_q.push_back(mkey[8*i +: 8]);
        end
        repeat (n_body)
            stream_q.push_back(8'($urandom_range(0, 255)));
        n_frames++;
    endtask

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, n_pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: changes its stall pattern after each run of random length, and once
    // holds off for a long stretch so the block backs up into s_tready.
    initial begin : receiver
        int         mode;
        logic [7:0] rdy_pat;
        bit         held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && n_sent >= HOLD_AFTER) begin
                held = 1'b1;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end
            mode    = $urandom_range(0, 3);
            rdy_pat = 8'($urandom_range(0, 255)) | 8'h01;
            repeat ($urandom_range(20, 120)) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;                          // no stalls
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: begin
                        m_tready <= rdy_pat[0];                   // rotating mask
                        rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
                    end
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        logic [7:0]  hdr0;
        logic [3:0]  op;
        int unsigned len;
        int unsigned pick;
        int unsigned burst_left;
        int unsigned gap;
        len_form_t   form;
        logic        masked_sel;

        // Directed frames:
        //   all-zero header byte, empty unmasked frame -> header-only result
        build_frame(8'h00, 64'd0, LEN_INLINE, 1'b0, 32'h0, 0);
        //   all-ones header byte, masked, one byte, all-ones key
        build_frame(8'hFF, 64'd1, LEN_INLINE, 1'b1, 32'hFFFF_FFFF, 1);
        //   16-bit length code carrying zero
        build_frame({1'b1, 3'b000, OP_BINARY}, 64'd0, LEN_EXT16, 1'b0, 32'h0, 0);
        //   non-minimal 64-bit length carrying one byte
        build_frame({1'b1, 3'b000, OP_PING}, 64'd1, LEN_EXT64, 1'b0, 32'h0, 1);
        //   masked empty frame: result comes with the last key byte
        build_frame({1'b0, 3'b000, OP_TEXT}, 64'd0, LEN_INLINE, 1'b1,
                    32'h0000_0000, 0);

        // Random frames: mostly RFC-legal headers, some with junk in the first
        // byte (reserved bits, reserved opcodes) and some long control frames.
        while (stream_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0:       op = OP_CONTINUATION;
                1:       op = OP_TEXT;
                2:       op = OP_BINARY;
                3:       op = OP_CLOSE;
                4:       op = OP_PING;
                default: op = OP_PONG;
            endcase
            if (pick < 20)
                hdr0 = 8'($urandom_range(0, 255));
            else
                hdr0 = {1'($urandom_range(0, 1)), 3'b000, op};

            pick = $urandom_range(0, 99);
            form = LEN_INLINE;
            if (pick < 45) begin
                len = $urandom_range(0, 8);
            end else if (pick < 70) begin
                len = $urandom_range(9, 125);
            end else if (pick < 78) begin
                len = 0;
            end else if (pick < 92) begin
                form = LEN_EXT16;
                len  = ($urandom_range(0, 19) == 0) ? $urandom_range(301, 1500)
                                                    : $urandom_range(0, 300);
            end else begin
                form = LEN_EXT64;
                len  = $urandom_range(0, 200);
            end
            masked_sel = ($urandom_range(0, 9) < 7);
            build_frame(hdr0, 64'(len), form, masked_sel, $urandom, len);
        end

        // Closing frame: 64-bit length with the top bit set; it never ends,
        // so it goes last with a short run of payload.
        build_frame({1'b1, 3'b000, OP_BINARY}, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64,
                    1'b1, $urandom, 24);

        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender: bursts of random length, random gaps; now and then a long
        // burst with no gaps at all.
        burst_left = $urandom_range(1, 16);
        foreach (stream_q[i]) begin
            s_tdata  <= stream_q[i];
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
            n_sent++;
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 16);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: sample the checker's count away from the clock edge.
        @(posedge aclk);
        @(negedge aclk);
        while (n_pending != 0)
            @(negedge aclk);
        // extra wait to catch any stray result
        repeat (8) @(posedge aclk);

        $display("Covered %0d stream bytes in %0d frames: %0d payload beats and %0d",
                 n_sent, n_frames, n_payload, n_empty);
        $display("header-only results checked, with stalls and a long hold-off.");
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
